[hdl/iil_pkg.sv]
// Package for the interval index lookup: widths, item codes, item and command types.
`timescale 1ns / 1ps
`default_nettype none
package iil_pkg;

  localparam int MAX_NOTES = 65536;
  localparam int IDX_W     = $clog2(MAX_NOTES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int MODE_W    = 2;
  localparam int NUM_W     = 17;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUR_W-1:0]  duration;
    logic [TIME_W-1:0] time_point;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] note_number;
    logic             in_range;
  } out_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic rd;
    logic upd;
    logic emit;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/iil_ctrl.sv]
// Controller state machine for the interval index lookup.
`timescale 1ns / 1ps
`default_nettype none
module iil_ctrl (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [iil_pkg::MODE_W-1:0]      mode,
  input  wire                             search_done,
  output logic                            busy,
  output iil_pkg::cmd_t                   cmd
);
  import iil_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_CLEAR:  cmd.clear  = 1'b1;
            MODE_APPEND: cmd.append = 1'b1;
            MODE_QUERY: begin
              cmd.load   = 1'b1;
              state_next = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (search_done) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.upd    = 1'b1;
        state_next = S_CHECK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[hdl/iil_datapath.sv]
// Datapath: note end memory, count and total registers, search bounds, result register.
`timescale 1ns / 1ps
`default_nettype none
module iil_datapath (
  input  wire                    clk,
  input  wire                    rst,
  input  iil_pkg::in_t           item,
  input  iil_pkg::cmd_t          cmd,
  output logic                   search_done,
  output logic                   result_valid,
  output iil_pkg::out_t          result
);
  import iil_pkg::*;

  logic [TIME_W-1:0] note_ends [MAX_NOTES];
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] total;
  logic [TIME_W-1:0] t_q;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  mid_q;
  logic [TIME_W-1:0] rdata;

  logic              empty;
  logic              full;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] total_next;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;

  assign empty       = (count == '0);
  assign full        = (count == CNT_W'(MAX_NOTES));
  assign sum         = {1'b0, total} + (TIME_W + 1)'(item.duration);
  assign total_next  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[IDX_W:1];
  assign search_done = empty || (lo == hi);

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      note_ends[count[IDX_W-1:0]] <= total_next;
    end
    if (cmd.rd) begin
      rdata <= note_ends[mid];
      mid_q <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.clear) begin
        count <= '0;
        total <= '0;
      end else if (cmd.append && !full) begin
        count <= count + CNT_W'(1);
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_q <= item.time_point;
      lo  <= '0;
      hi  <= empty ? '0 : IDX_W'(count - CNT_W'(1));
    end else if (cmd.upd) begin
      if (rdata > t_q) begin
        hi <= mid_q;
      end else begin
        lo <= mid_q + IDX_W'(1);
      end
    end
    if (cmd.emit) begin
      result.note_number <= empty ? '0 : NUM_W'(CNT_W'(lo) + CNT_W'(1));
      result.in_range    <= !empty && (t_q < total);
    end
  end

endmodule
`default_nettype wire

[hdl/interval_index_lookup.sv]
// Interval index lookup: note table built from durations, located by binary search.
// Clear and append complete in the accept cycle; busy stays low, next item the cycle after.
// Query: busy while the search runs (an empty or one-note table needs only the first check),
//   result strobe in the cycle after the final check; each search step is one memory read
//   and one compare.
// Results cannot be stalled. Synchronous reset empties the table; no clearing pass,
//   the note memory needs none as only stored entries are read.
`timescale 1ns / 1ps
`default_nettype none
module interval_index_lookup (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  iil_pkg::in_t          item,
  output logic                  busy,
  output logic                  result_valid,
  output iil_pkg::out_t         result
);
  import iil_pkg::*;

  cmd_t cmd;
  logic search_done;

  iil_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (item.mode),
    .search_done (search_done),
    .busy        (busy),
    .cmd         (cmd)
  );

  iil_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .search_done  (search_done),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_QUERY) |=> busy)
    else $error("query item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_range_needs_note: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.in_range) |-> (result.note_number != '0))
    else $error("in_range set with no containing note");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy))
    else $error("result produced without a query in progress");
`endif

endmodule
`default_nettype wire
